// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the parser rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SEMP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SEMP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEMP_ASSERT(label, clk, rst, prop, msg)
`define SEMP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/semp_pkg.sv =====
// types, marker codes and defaults for the stripe entity marker parser
// no dependencies
`default_nettype none
package semp_pkg;
   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] M_ESC     = 8'hff;
   localparam logic [7:0] M_STUFF   = 8'h00;
   localparam logic [7:0] M_SDNORM  = 8'h02;
   localparam logic [7:0] M_SDRST   = 8'h03;
   localparam logic [7:0] M_ABORT   = 8'h04;
   localparam logic [7:0] M_NEWLEN  = 8'h05;
   localparam logic [7:0] M_ATMOVE  = 8'h06;
   localparam logic [7:0] M_COMMENT = 8'h07;

   localparam logic [31:0] START_OFFSET_RESET = 32'd20;
   localparam logic [20:0] ENTITY_LIMIT_RESET = 21'd0;

   typedef enum logic {
      CSR_START_OFFSET = 1'b0,
      CSR_ENTITY_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_TOP, PH_TOP_ESC, PH_ENT, PH_ENT_ESC, PH_NEWLEN, PH_MOVE, PH_CLEN, PH_CBODY
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ENTITY = 2'd0,
      KIND_MOVE   = 2'd1,
      KIND_HEIGHT = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   // one result word as it leaves the block
   typedef struct packed {
      kind_type    kind;
      logic [31:0] entity_offset;
      logic [31:0] entity_length;
      logic        ends_with_reset;
      logic [31:0] first_move_index;
      logic [31:0] moves_before;
      logic [31:0] word_value;
      logic [7:0]  move_x;
      logic [7:0]  move_y;
      logic        status;
      logic [31:0] entity_total;
      logic        last;
   } rsp_word_type;

   // everything one input byte causes: an optional word and an optional done
   typedef struct packed {
      logic         has_prim;
      rsp_word_type prim;
      logic         has_done;
      logic         done_status;
      logic [31:0]  done_total;
   } entry_type;
endpackage
`default_nettype wire

// ===== hw/rtl/semp_front.sv =====
// front part: byte-level marker parsing, one byte per cycle while accept is high
// depends on semp_pkg
`default_nettype none
module semp_front import semp_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   input  wire logic        end_of_data,
   input  wire logic [31:0] start_offset,
   input  wire logic [20:0] entity_limit,
   output logic             wr_en,
   output entry_type        wr_entry
);
   localparam int PB = POSITION_BITS;

   phase_type       phase_ff, phase_in;
   logic [2:0]      seg_cnt_ff, seg_cnt_in;
   logic [47:0]     seg_buf_ff, seg_buf_in;
   logic            seg_in_ent_ff, seg_in_ent_in;
   logic [PB-1:0]   pos_ff, pos_in;
   logic [PB-1:0]   ent_start_ff, ent_start_in;
   logic [PB-1:0]   ent_end_ff, ent_end_in;
   logic            early_ff, early_in;
   logic            height_seen_ff, height_seen_in;
   logic [31:0]     ent_count_ff, ent_count_in;
   logic [31:0]     move_count_ff, move_count_in;
   logic [31:0]     pending_ff, pending_in;
   logic [31:0]     comment_left_ff, comment_left_in;
   logic            stopped_ff, stopped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TOP;
         seg_cnt_ff      <= '0;
         seg_buf_ff      <= '0;
         seg_in_ent_ff   <= 1'b0;
         pos_ff          <= '0;
         ent_start_ff    <= '0;
         ent_end_ff      <= '0;
         early_ff        <= 1'b0;
         height_seen_ff  <= 1'b0;
         ent_count_ff    <= '0;
         move_count_ff   <= '0;
         pending_ff      <= '0;
         comment_left_ff <= '0;
         stopped_ff      <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         seg_cnt_ff      <= seg_cnt_in;
         seg_buf_ff      <= seg_buf_in;
         seg_in_ent_ff   <= seg_in_ent_in;
         pos_ff          <= pos_in;
         ent_start_ff    <= ent_start_in;
         ent_end_ff      <= ent_end_in;
         early_ff        <= early_in;
         height_seen_ff  <= height_seen_in;
         ent_count_ff    <= ent_count_in;
         move_count_ff   <= move_count_in;
         pending_ff      <= pending_in;
         comment_left_ff <= comment_left_in;
         stopped_ff      <= stopped_in;
      end
   end

   always_comb begin
      logic [PB-1:0] esc_pos;
      logic [PB-1:0] end_pos;
      logic [47:0]   buf_new;
      logic [2:0]    cnt_new;
      logic [31:0]   cl;
      logic          stop;
      logic          finish;
      logic          status;

      phase_in        = phase_ff;
      seg_cnt_in      = seg_cnt_ff;
      seg_buf_in      = seg_buf_ff;
      seg_in_ent_in   = seg_in_ent_ff;
      pos_in          = pos_ff;
      ent_start_in    = ent_start_ff;
      ent_end_in      = ent_end_ff;
      early_in        = early_ff;
      height_seen_in  = height_seen_ff;
      ent_count_in    = ent_count_ff;
      move_count_in   = move_count_ff;
      pending_in      = pending_ff;
      comment_left_in = comment_left_ff;
      stopped_in      = stopped_ff;
      wr_entry        = '0;
      stop            = 1'b0;
      finish          = 1'b0;
      status          = 1'b0;
      esc_pos         = pos_ff - PB'(1);
      end_pos         = early_ff ? ent_end_ff : esc_pos;
      buf_new         = {seg_buf_ff[39:0], data_byte};
      cnt_new         = seg_cnt_ff + 3'd1;
      cl              = comment_left_ff;

      if (accept && !stopped_ff) begin
         case (phase_ff)
            PH_TOP: begin
               ent_start_in = pos_ff;
               early_in     = 1'b0;
               phase_in     = (data_byte == M_ESC) ? PH_TOP_ESC : PH_ENT;
            end
            PH_TOP_ESC: begin
               seg_cnt_in    = '0;
               seg_buf_in    = '0;
               seg_in_ent_in = 1'b0;
               case (data_byte)
                  M_ABORT:            stop = 1'b1;
                  M_NEWLEN:           phase_in = PH_NEWLEN;
                  M_ATMOVE:           phase_in = PH_MOVE;
                  M_COMMENT:          phase_in = PH_CLEN;
                  M_STUFF:            phase_in = PH_ENT;
                  M_SDNORM, M_SDRST:  finish = 1'b1;
                  default: begin
                     stop   = 1'b1;
                     status = 1'b1;
                  end
               endcase
            end
            PH_ENT: begin
               if (data_byte == M_ESC) begin
                  phase_in = PH_ENT_ESC;
               end else if (early_ff) begin
                  stop   = 1'b1;
                  status = 1'b1;
               end
            end
            PH_ENT_ESC: begin
               if (data_byte == M_STUFF && !early_ff) begin
                  phase_in = PH_ENT;
               end else if (data_byte == M_SDNORM || data_byte == M_SDRST) begin
                  finish = 1'b1;
               end else if (data_byte == M_NEWLEN) begin
                  if (!early_ff) begin
                     ent_end_in = esc_pos;
                  end
                  early_in      = 1'b1;
                  phase_in      = PH_NEWLEN;
                  seg_cnt_in    = '0;
                  seg_buf_in    = '0;
                  seg_in_ent_in = 1'b1;
               end else begin
                  stop   = 1'b1;
                  status = 1'b1;
               end
            end
            PH_NEWLEN: begin
               seg_buf_in = buf_new;
               seg_cnt_in = cnt_new;
               if (cnt_new == 3'd4) begin
                  if (!height_seen_ff) begin
                     height_seen_in           = 1'b1;
                     wr_entry.has_prim        = 1'b1;
                     wr_entry.prim.kind       = KIND_HEIGHT;
                     wr_entry.prim.word_value = buf_new[31:0];
                  end
                  phase_in = seg_in_ent_ff ? PH_ENT : PH_TOP;
               end
            end
            PH_MOVE: begin
               seg_buf_in = buf_new;
               seg_cnt_in = cnt_new;
               if (cnt_new == 3'd6) begin
                  // a move on the current line (y zero) whose x has its top bit set is invalid
                  if (buf_new[7:0] == 8'd0 && buf_new[15]) begin
                     stop   = 1'b1;
                     status = 1'b1;
                  end else begin
                     wr_entry.has_prim              = 1'b1;
                     wr_entry.prim.kind             = KIND_MOVE;
                     wr_entry.prim.first_move_index = move_count_ff;
                     wr_entry.prim.word_value       = buf_new[47:16];
                     wr_entry.prim.move_x           = buf_new[15:8];
                     wr_entry.prim.move_y           = buf_new[7:0];
                     move_count_in                  = move_count_ff + 32'd1;
                     pending_in                     = pending_ff + 32'd1;
                     phase_in                       = PH_TOP;
                  end
               end
            end
            PH_CLEN: begin
               seg_buf_in = buf_new;
               seg_cnt_in = cnt_new;
               if (cnt_new == 3'd4) begin
                  comment_left_in = buf_new[31:0];
                  phase_in = (buf_new[31:0] != 32'd0) ? PH_CBODY : PH_TOP;
               end
            end
            PH_CBODY: begin
               if (cl != 32'd0) begin
                  cl = cl - 32'd1;
               end
               comment_left_in = cl;
               if (cl == 32'd0) begin
                  phase_in = PH_TOP;
               end
            end
            default: phase_in = PH_TOP;
         endcase

         if (finish) begin
            wr_entry.has_prim              = 1'b1;
            wr_entry.prim.kind             = KIND_ENTITY;
            wr_entry.prim.entity_offset    = 32'(PB'(start_offset) + ent_start_ff);
            wr_entry.prim.entity_length    = 32'(end_pos - ent_start_ff);
            wr_entry.prim.ends_with_reset  = (data_byte == M_SDRST);
            wr_entry.prim.first_move_index = move_count_ff - pending_ff;
            wr_entry.prim.moves_before     = pending_ff;
            pending_in                     = '0;
            ent_count_in                   = ent_count_ff + 32'd1;
            phase_in                       = PH_TOP;
            if (entity_limit != 21'd0 && ent_count_in == {11'd0, entity_limit}) begin
               stop = 1'b1;
            end
         end

         pos_in = pos_ff + PB'(1);
         if (end_of_data) begin
            stop = 1'b1;
         end
         if (stop) begin
            wr_entry.has_done    = 1'b1;
            wr_entry.done_status = status;
            wr_entry.done_total  = ent_count_in;
            stopped_in           = 1'b1;
         end
      end
      wr_en = wr_entry.has_prim || wr_entry.has_done;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/semp_queue.sv =====
// short queue between the parsing front and the output back part
// depends on semp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module semp_queue import semp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  entry_type push_entry,
   input  wire logic pop,
   output entry_type head_entry,
   output logic      not_empty,
   output logic      full
);
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
   end

   assign head_entry = mem_ff[rd_ptr_ff];
   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == (PTR_BITS+1)'(QUEUE_DEPTH));

   `SEMP_ASSERT(a_no_overflow, clock, reset, push |-> !full, "push into full queue")
   `SEMP_ASSERT(a_no_underflow, clock, reset, pop |-> not_empty, "pop from empty queue")
   `SEMP_ASSERT(a_count_range, clock, reset,
      count_ff <= (PTR_BITS+1)'(QUEUE_DEPTH), "queue count out of range")
endmodule
`default_nettype wire

// ===== hw/rtl/semp_back.sv =====
// back part: expands queued entries into result words behind an output register
// depends on semp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module semp_back import semp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  entry_type    head_entry,
   input  wire logic    not_empty,
   output logic         pop,
   output rsp_word_type out_word,
   output logic         out_valid,
   input  wire logic    out_ready
);
   rsp_word_type word_ff, word_in;
   rsp_word_type done_ff, done_in;
   logic         valid_ff, valid_in;
   logic         pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      word_ff <= word_in;
      done_ff <= done_in;
   end

   always_comb begin
      rsp_word_type done_w;
      logic         slot_free;

      done_w              = '0;
      done_w.kind         = KIND_DONE;
      done_w.status       = head_entry.done_status;
      done_w.entity_total = head_entry.done_total;
      done_w.last         = 1'b1;

      slot_free = !valid_ff || out_ready;
      word_in   = word_ff;
      done_in   = done_ff;
      valid_in  = valid_ff && !out_ready;
      pend_in   = pend_ff;
      pop       = 1'b0;

      if (slot_free) begin
         if (pend_ff) begin
            word_in  = done_ff;
            valid_in = 1'b1;
            pend_in  = 1'b0;
         end else if (not_empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head_entry.has_prim) begin
               word_in      = head_entry.prim;
               word_in.last = !head_entry.has_done;
               pend_in      = head_entry.has_done;
               done_in      = done_w;
            end else begin
               word_in = done_w;
            end
         end
      end
   end

   assign out_word  = word_ff;
   assign out_valid = valid_ff;

   `SEMP_ASSERT(a_pend_has_word, clock, reset, pend_ff |-> valid_ff,
      "done pending without a word in the output register")
   `SEMP_ASSERT(a_no_pop_while_pend, clock, reset, pend_ff |-> !pop,
      "entry popped while a done word waits")
   `SEMP_ASSERT(a_pend_is_done, clock, reset, pend_ff |-> done_ff.kind == KIND_DONE,
      "pending word is not a done word")
endmodule
`default_nettype wire

// ===== hw/rtl/stripe_entity_marker_parser.sv =====
// stripe entity marker parser, top level: front parser, queue, back output stage
// depends on semp_pkg, semp_front, semp_queue, semp_back
//
// takes the image data that follows the header one byte per req word (tlast on
// the final byte) and reports stripe data entities, template moves, the first
// new height and a closing done word on the rsp side. a byte is taken every
// cycle while the four-entry result queue has room; a byte gives at most two rsp
// words, the second always the done word, so the output stage sends one word per
// cycle while rsp_tready is high, and only the byte that stops parsing gives two
// words. a byte's first rsp word goes through a queue entry and the output register.
// after done, further bytes are taken and dropped until reset. the csr port
// takes a write every cycle; index 0 is start_offset, index 1 is entity_limit.
`default_nettype none
module stripe_entity_marker_parser import semp_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // input words
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // data_byte
   input  wire logic         req_tlast,   // end_of_data
   // result words
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // entity_offset[31:0], entity_length[63:32], ends_with_reset[64],
   // first_move_index[96:65], moves_before[128:97], word_value[160:129],
   // move_x[168:161], move_y[176:169], status[177], entity_total[209:178],
   // zero fill [215:210]
   output logic [215:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,   // kind
   output logic              rsp_tlast,   // last
   // register writes
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_data
);
   logic [31:0]  start_offset_ff;
   logic [20:0]  entity_limit_ff;
   logic         accept;
   logic         wr_en;
   entry_type    wr_entry;
   entry_type    head_entry;
   logic         not_empty;
   logic         full;
   logic         pop;
   rsp_word_type out_word;

   // registers are written whenever offered
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= START_OFFSET_RESET;
         entity_limit_ff <= ENTITY_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_START_OFFSET: start_offset_ff <= csr_data;
            CSR_ENTITY_LIMIT: entity_limit_ff <= csr_data[20:0];
            default: ;
         endcase
      end
   end

   // a full queue holds back the front, which covers the two-word case
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   semp_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .end_of_data  (req_tlast),
      .start_offset (start_offset_ff),
      .entity_limit (entity_limit_ff),
      .wr_en        (wr_en),
      .wr_entry     (wr_entry)
   );

   semp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (wr_en),
      .push_entry (wr_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .full       (full)
   );

   semp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .pop        (pop),
      .out_word   (out_word),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready)
   );

   // pack the output word, first field lowest
   assign rsp_tdata = {6'd0,
                       out_word.entity_total,
                       out_word.status,
                       out_word.move_y,
                       out_word.move_x,
                       out_word.word_value,
                       out_word.moves_before,
                       out_word.first_move_index,
                       out_word.ends_with_reset,
                       out_word.entity_length,
                       out_word.entity_offset};
   assign rsp_tuser = out_word.kind;
   assign rsp_tlast = out_word.last;
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for stripe_entity_marker_parser: directed and random marker
// streams in, words checked against an in-bench parse model; depends on semp_pkg and the parser rtl
`timescale 1ns / 1ps
module testbench;
   import semp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [215:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_data = '0;

   stripe_entity_marker_parser DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bytes waiting for the driver: {end_of_data, data_byte}
   logic [8:0]   byte_queue[$];
   // words the parser still owes us, oldest first
   rsp_word_type owed_words[$];
   int           errors = 0;
   int           cycles = 0;
   bit           steady = 1'b0;   // no idling on either side while set

   // parse model state
   phase_type    phase = PH_TOP;
   logic [2:0]   seg_cnt = '0;
   logic [47:0]  seg_buf = '0;
   logic         seg_in_ent = 1'b0;
   logic [31:0]  byte_pos = '0;
   logic [31:0]  ent_start = '0;
   logic [31:0]  ent_end = '0;
   logic         cut_short = 1'b0;
   logic         height_seen = 1'b0;
   logic [31:0]  ent_cnt = '0;
   logic [31:0]  mv_cnt = '0;
   logic [31:0]  mv_pending = '0;
   logic [31:0]  cmt_left = '0;
   logic         halted = 1'b0;
   logic [31:0]  base_offset = START_OFFSET_RESET;
   logic [20:0]  ent_limit = ENTITY_LIMIT_RESET;

   // advance the parse model by one byte and queue the words it gives
   function automatic void parse_byte(logic [7:0] b, logic eod);
      rsp_word_type w;
      rsp_word_type made[$];
      logic [31:0]  pos, esc_pos, fin_end;
      logic [7:0]   tx, ty;
      logic         stop, finish, bad;
      if (halted) return;
      pos = byte_pos;
      esc_pos = pos - 1;
      stop = 1'b0;
      finish = 1'b0;
      bad = 1'b0;
      w = '0;
      case (phase)
         PH_TOP: begin
            ent_start = pos;
            cut_short = 1'b0;
            phase = (b == M_ESC) ? PH_TOP_ESC : PH_ENT;
         end
         PH_TOP_ESC: begin
            seg_cnt = '0;
            seg_buf = '0;
            seg_in_ent = 1'b0;
            if (b == M_ABORT) stop = 1'b1;
            else if (b == M_NEWLEN) phase = PH_NEWLEN;
            else if (b == M_ATMOVE) phase = PH_MOVE;
            else if (b == M_COMMENT) phase = PH_CLEN;
            else if (b == M_STUFF) phase = PH_ENT;
            else if (b == M_SDNORM || b == M_SDRST) finish = 1'b1;
            else begin
               stop = 1'b1;
               bad = 1'b1;
            end
         end
         PH_ENT: begin
            if (b == M_ESC) phase = PH_ENT_ESC;
            else if (cut_short) begin
               stop = 1'b1;
               bad = 1'b1;
            end
         end
         PH_ENT_ESC: begin
            if (b == M_STUFF && !cut_short) phase = PH_ENT;
            else if (b == M_SDNORM || b == M_SDRST) finish = 1'b1;
            else if (b == M_NEWLEN) begin
               if (!cut_short) ent_end = esc_pos;
               cut_short = 1'b1;
               phase = PH_NEWLEN;
               seg_cnt = '0;
               seg_buf = '0;
               seg_in_ent = 1'b1;
            end else begin
               stop = 1'b1;
               bad = 1'b1;
            end
         end
         PH_NEWLEN: begin
            seg_buf = {seg_buf[39:0], b};
            seg_cnt = seg_cnt + 1;
            if (seg_cnt == 4) begin
               if (!height_seen) begin
                  height_seen = 1'b1;
                  w.kind = KIND_HEIGHT;
                  w.word_value = seg_buf[31:0];
                  made.push_back(w);
               end
               phase = seg_in_ent ? PH_ENT : PH_TOP;
            end
         end
         PH_MOVE: begin
            seg_buf = {seg_buf[39:0], b};
            seg_cnt = seg_cnt + 1;
            if (seg_cnt == 6) begin
               tx = seg_buf[15:8];
               ty = seg_buf[7:0];
               if (ty == 0 && tx[7]) begin
                  stop = 1'b1;
                  bad = 1'b1;
               end else begin
                  w.kind = KIND_MOVE;
                  w.first_move_index = mv_cnt;
                  w.word_value = seg_buf[47:16];
                  w.move_x = tx;
                  w.move_y = ty;
                  made.push_back(w);
                  mv_cnt = mv_cnt + 1;
                  mv_pending = mv_pending + 1;
                  phase = PH_TOP;
               end
            end
         end
         PH_CLEN: begin
            seg_buf = {seg_buf[39:0], b};
            seg_cnt = seg_cnt + 1;
            if (seg_cnt == 4) begin
               cmt_left = seg_buf[31:0];
               phase = (cmt_left != 0) ? PH_CBODY : PH_TOP;
            end
         end
         default: begin
            if (cmt_left > 0) cmt_left = cmt_left - 1;
            if (cmt_left == 0) phase = PH_TOP;
         end
      endcase

      if (finish) begin
         fin_end = cut_short ? ent_end : esc_pos;
         w = '0;
         w.kind = KIND_ENTITY;
         w.entity_offset = base_offset + ent_start;
         w.entity_length = fin_end - ent_start;
         w.ends_with_reset = (b == M_SDRST);
         w.first_move_index = mv_cnt - mv_pending;
         w.moves_before = mv_pending;
         made.push_back(w);
         mv_pending = '0;
         ent_cnt = ent_cnt + 1;
         phase = PH_TOP;
         if (ent_limit != 0 && ent_cnt == {11'b0, ent_limit}) stop = 1'b1;
      end

      byte_pos = pos + 1;
      if (eod) stop = 1'b1;
      if (stop) begin
         w = '0;
         w.kind = KIND_DONE;
         w.status = bad;
         w.entity_total = ent_cnt;
         made.push_back(w);
         halted = 1'b1;
      end
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) owed_words.push_back(made[i]);
   endfunction

   // driver: one byte word per handshake, random gaps unless steady
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
               req_tvalid <= 1'b1;
               {req_tlast, req_tdata} <= byte_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // monitor: random back-pressure, each accepted word against the oldest owed one
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || $urandom_range(99) >= 20;
         if (rsp_tvalid && rsp_tready) begin
            if (owed_words.size() == 0) begin
               $display("%0t: unexpected word, expected none actual kind %0d tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               want = owed_words.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("entity_offset", want.entity_offset, rsp_tdata[31:0]);
               check_field("entity_length", want.entity_length, rsp_tdata[63:32]);
               check_field("ends_with_reset", want.ends_with_reset, rsp_tdata[64]);
               check_field("first_move_index", want.first_move_index, rsp_tdata[96:65]);
               check_field("moves_before", want.moves_before, rsp_tdata[128:97]);
               check_field("word_value", want.word_value, rsp_tdata[160:129]);
               check_field("move_x", want.move_x, rsp_tdata[168:161]);
               check_field("move_y", want.move_y, rsp_tdata[176:169]);
               check_field("status", want.status, rsp_tdata[177]);
               check_field("entity_total", want.entity_total, rsp_tdata[209:178]);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** stripe_entity_marker_parser: FAILED **");
         $finish;
      end
   end

   // stream building helpers
   task automatic put(logic [7:0] b);
      byte_queue.push_back({1'b0, b});
   endtask

   task automatic put_word32(logic [31:0] v);
      put(v[31:24]); put(v[23:16]); put(v[15:8]); put(v[7:0]);
   endtask

   // coded byte with ff stuffing, ff made common on purpose
   task automatic put_coded();
      logic [7:0] b;
      b = ($urandom_range(7) == 0) ? M_ESC : 8'($urandom_range(255));
      put(b);
      if (b == M_ESC) put(M_STUFF);
   endtask

   task automatic add_entity(int n, bit rst, bit cut);
      repeat (n) put_coded();
      if (cut) begin
         put(M_ESC); put(M_NEWLEN); put_word32($urandom);
      end
      put(M_ESC); put(rst ? M_SDRST : M_SDNORM);
   endtask

   task automatic add_move(logic [31:0] line, logic [7:0] x, logic [7:0] y);
      put(M_ESC); put(M_ATMOVE); put_word32(line); put(x); put(y);
   endtask

   task automatic add_comment(int n);
      put(M_ESC); put(M_COMMENT); put_word32(n);
      repeat (n) put(($urandom_range(3) == 0) ? M_ESC : 8'($urandom_range(255)));
   endtask

   task automatic add_random_segment();
      int pick;
      logic [7:0] x, y;
      pick = $urandom_range(99);
      if (pick < 55) begin
         add_entity(($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(8),
                    $urandom_range(1), $urandom_range(5) == 0);
      end else if (pick < 75) begin
         x = $urandom_range(255);
         y = $urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(255));
         if (y == 0) x[7] = 1'b0;
         add_move($urandom, x, y);
      end else if (pick < 85) begin
         put(M_ESC); put(M_NEWLEN); put_word32($urandom);
      end else begin
         add_comment($urandom_range(6));
      end
   endtask

   // wait until every byte is taken and every owed word is back, then drain
   // (checked at the falling edge, once the clocked blocks have settled)
   task automatic settle();
      while (byte_queue.size() > 0 || req_tvalid || owed_words.size() > 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_START_OFFSET) base_offset = v;
      else ent_limit = v[20:0];
      csr_valid <= 1'b0;
   endtask

   initial begin
      int ending;
      logic [31:0] offsets[5];
      offsets = '{32'h0, 32'hffff_ffff, 32'hffff_fff0, 32'd20, 32'h0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(CSR_START_OFFSET, 32'hffff_fffe);
      write_reg(CSR_ENTITY_LIMIT, 32'd1048576);

      // directed: empty entities, stuffed first byte, move extremes, heights,
      // comments, an entity cut by a height
      add_entity(0, 0, 0);
      add_entity(0, 1, 0);
      put(M_ESC); put(M_STUFF); put(8'h00); put(M_ESC); put(M_SDNORM);
      add_move(32'hffff_ffff, 8'h7f, 8'h00);
      add_move(32'h0, 8'h80, 8'hff);
      put(M_ESC); put(M_NEWLEN); put_word32(32'hffff_ffff);
      add_entity(3, 1, 1);
      add_comment(0);
      add_comment(3);
      add_entity(2, 0, 0);
      settle();

      for (int ph = 0; ph < 9; ph++) begin
         steady = (ph == 3);
         repeat ($urandom_range(12, 20)) add_random_segment();
         settle();
         steady = 1'b0;
         if (ph < 5) write_reg(CSR_START_OFFSET, (ph == 4) ? $urandom : offsets[ph]);
         else write_reg(CSR_ENTITY_LIMIT, (ph == 5) ? 32'd0 : ent_cnt + 50);
      end

      // the run ends in one of the stopping cases
      ending = $urandom_range(7);
      case (ending)
         0: begin put(M_ESC); put(M_ABORT); end
         1: begin put(M_ESC); put(8'($urandom_range(8'h08, 8'hfe))); end
         2: add_move($urandom, 8'($urandom_range(128, 255)), 8'h00);
         3: begin
            put_coded(); put_coded();
            byte_queue.push_back({1'b1, 8'h11});
         end
         4: begin
            settle();
            write_reg(CSR_ENTITY_LIMIT, ent_cnt + 1);
            add_entity(2, 1, 0);
         end
         5: begin
            put(8'h12); put(M_ESC); put(M_NEWLEN); put_word32($urandom); put(8'h34);
         end
         6: begin
            put(8'h12); put(M_ESC); put(M_NEWLEN); put_word32($urandom);
            put(M_ESC); put(M_STUFF);
         end
         default: begin
            put(8'h55); put(M_ESC);
            byte_queue.push_back({1'b1, M_SDNORM});
         end
      endcase
      // bytes after done are dropped
      repeat (4) put($urandom_range(255));
      byte_queue.push_back({1'b1, 8'($urandom_range(255))});
      settle();

      if (errors == 0 && owed_words.size() == 0) begin
         $display("** stripe_entity_marker_parser: PASSED **");
      end else begin
         if (owed_words.size() > 0)
            $display("%0t: %0d words expected but never sent, actual none",
                     $time, owed_words.size());
         $display("** stripe_entity_marker_parser: FAILED **");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/semp_pkg.sv
hw/rtl/semp_front.sv
hw/rtl/semp_queue.sv
hw/rtl/semp_back.sv
hw/rtl/stripe_entity_marker_parser.sv
verif/testbench.sv
